[rtl/rapq_pkg.sv]
// Shared constants and types for the range-add / point-query segment tree.
package rapq_pkg;

	localparam int MAX_POSITIONS_DEF = 1024;

	// Field widths are fixed by the interface.
	localparam int POS_W = 11;
	localparam int ACT_W = 11;
	localparam int VAL_W = 64;

	// Configuration port.
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_ACTIVE_SIZE = 1'b0;

	typedef enum logic {
		FUNC_ADD   = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	// Command lines of the node store.
	typedef struct packed {
		logic we;
		logic re;
	} mem_ctl_t;

endpackage

[rtl/rapq_node_ram.sv]
// Node addend store: single-port synchronous RAM, registered read data.
module rapq_node_ram import rapq_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  logic                                   clk,
	input  mem_ctl_t                               ctl,
	input  logic [$clog2(MAX_POSITIONS):0]         addr,
	input  logic [VAL_W-1:0]                       wdata,
	output logic [VAL_W-1:0]                       rdata
);

	localparam int NODE_AW = $clog2(MAX_POSITIONS) + 1;
	localparam int DEPTH   = 1 << NODE_AW;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= wdata;
		end
		if (ctl.re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/rapq_walk.sv]
// Tree walk sequencer: clear pass, range add decomposition, point query path sum.
module rapq_walk import rapq_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [POS_W-1:0]                       top_pos,
	input  logic                                   req_valid,
	output logic                                   req_ready,
	input  logic                                   func,
	input  logic [POS_W-1:0]                       low_pos,
	input  logic [POS_W-1:0]                       high_pos,
	input  logic signed [VAL_W-1:0]                amount,
	output logic                                   rsp_valid,
	input  logic                                   rsp_ready,
	output logic signed [VAL_W-1:0]                point_total,
	output mem_ctl_t                               mem_ctl,
	output logic [$clog2(MAX_POSITIONS):0]         mem_addr,
	output logic [VAL_W-1:0]                       mem_wdata,
	input  logic [VAL_W-1:0]                       mem_rdata
);

	localparam int NODE_AW = $clog2(MAX_POSITIONS) + 1;
	localparam logic [NODE_AW-1:0] ROOT_K = NODE_AW'(1);
	localparam logic [POS_W-1:0]   POS_ONE = POS_W'(1);

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_A_ROOT = 8'b0000_0100,
		ST_A_STEP = 8'b0000_1000,
		ST_A_ADDW = 8'b0001_0000,
		ST_Q_RD   = 8'b0010_0000,
		ST_Q_LAST = 8'b0100_0000,
		ST_Q_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [NODE_AW-1:0]      clr_addr_q;
	logic [POS_W-1:0]        lo_q;
	logic [POS_W-1:0]        hi_q;
	logic [VAL_W-1:0]        amt_q;
	logic [VAL_W-1:0]        acc_q;
	logic                    qpend_q;
	logic [NODE_AW-1:0]      tk_q;

	// query walk
	logic [POS_W-1:0]        s_q;
	logic [POS_W-1:0]        e_q;
	logic [NODE_AW-1:0]      k_q;

	// partial nodes of the current and the next level
	logic [POS_W-1:0]        cur_s_q [2];
	logic [POS_W-1:0]        cur_e_q [2];
	logic [NODE_AW-1:0]      cur_k_q [2];
	logic [POS_W-1:0]        nxt_s_q [2];
	logic [POS_W-1:0]        nxt_e_q [2];
	logic [NODE_AW-1:0]      nxt_k_q [2];
	logic [1:0]              cur_cnt_q;
	logic [1:0]              nxt_cnt_q;
	logic                    slot_q;
	logic                    child_q;

	logic                    rsp_valid_q;
	logic [VAL_W-1:0]        rsp_data_q;

	logic                    accept;
	logic [POS_W-1:0]        lo_clip;
	logic [POS_W-1:0]        hi_clip;
	logic                    q_out;

	logic [POS_W-1:0]        par_s;
	logic [POS_W-1:0]        par_e;
	logic [NODE_AW-1:0]      par_k;
	logic [POS_W:0]          par_sum;
	logic [POS_W-1:0]        par_mid;
	logic [POS_W:0]          q_sum;
	logic [POS_W-1:0]        q_mid;
	logic [POS_W-1:0]        cand_s;
	logic [POS_W-1:0]        cand_e;
	logic [NODE_AW-1:0]      cand_k;
	logic                    cand_full;
	logic                    cand_disj;
	logic                    slot_live;
	logic                    rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	// Clip the add span to the live range; an empty result means no work.
	assign lo_clip = (low_pos == '0) ? POS_ONE : low_pos;
	assign hi_clip = (high_pos > top_pos) ? top_pos : high_pos;
	assign q_out   = (low_pos == '0) || (low_pos > top_pos);

	assign par_s   = cur_s_q[slot_q];
	assign par_e   = cur_e_q[slot_q];
	assign par_k   = cur_k_q[slot_q];
	assign par_sum = {1'b0, par_s} + {1'b0, par_e};
	assign par_mid = par_sum[POS_W:1];
	assign q_sum   = {1'b0, s_q} + {1'b0, e_q};
	assign q_mid   = q_sum[POS_W:1];

	assign slot_live = slot_q ? (cur_cnt_q == 2'd2) : (cur_cnt_q != 2'd0);

	always_comb begin
		if (state_q == ST_A_ROOT) begin
			cand_s = POS_ONE;
			cand_e = top_pos;
			cand_k = ROOT_K;
		end else if (!child_q) begin
			cand_s = par_s;
			cand_e = par_mid;
			cand_k = {par_k[NODE_AW-2:0], 1'b0};
		end else begin
			cand_s = par_mid + POS_ONE;
			cand_e = par_e;
			cand_k = {par_k[NODE_AW-2:0], 1'b1};
		end
	end

	assign cand_full = (lo_q <= cand_s) && (cand_e <= hi_q);
	assign cand_disj = (cand_e < lo_q) || (hi_q < cand_s);

	always_comb begin
		mem_ctl   = '0;
		mem_addr  = '0;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_ctl.we = 1'b1;
				mem_addr   = clr_addr_q;
			end
			ST_A_ROOT, ST_A_STEP: begin
				if (cand_full && (state_q == ST_A_ROOT || slot_live)) begin
					mem_ctl.re = 1'b1;
					mem_addr   = cand_k;
				end
			end
			ST_A_ADDW: begin
				mem_ctl.we = 1'b1;
				mem_addr   = tk_q;
				mem_wdata  = mem_rdata + amt_q;
			end
			ST_Q_RD: begin
				mem_ctl.re = 1'b1;
				mem_addr   = k_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			cur_cnt_q   <= '0;
			nxt_cnt_q   <= '0;
			slot_q      <= 1'b0;
			child_q     <= 1'b0;
			qpend_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			qpend_q <= (state_q == ST_Q_RD);
			// A finished query loads the result register once it is free.
			if (state_q == ST_Q_FIN && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + NODE_AW'(1);
					if (&clr_addr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (func == FUNC_ADD) begin
							if (lo_clip <= hi_clip) begin
								state_q <= ST_A_ROOT;
							end
						end else if (q_out) begin
							state_q <= ST_Q_FIN;
						end else begin
							state_q <= ST_Q_RD;
						end
					end
				end
				ST_A_ROOT: begin
					cur_cnt_q <= '0;
					slot_q    <= 1'b0;
					child_q   <= 1'b0;
					if (cand_full) begin
						nxt_cnt_q <= '0;
						state_q   <= ST_A_ADDW;
					end else begin
						nxt_cnt_q <= 2'd1;
						state_q   <= ST_A_STEP;
					end
				end
				ST_A_STEP: begin
					if (!slot_live) begin
						// level finished: descend or stop
						if (nxt_cnt_q == 2'd0) begin
							state_q <= ST_IDLE;
						end else begin
							cur_cnt_q <= nxt_cnt_q;
							nxt_cnt_q <= '0;
							slot_q    <= 1'b0;
							child_q   <= 1'b0;
						end
					end else begin
						child_q <= !child_q;
						if (child_q) begin
							slot_q <= !slot_q;
							// second partial node done: level is used up
							if (slot_q) begin
								cur_cnt_q <= '0;
							end
						end
						if (cand_full) begin
							state_q <= ST_A_ADDW;
						end else if (!cand_disj) begin
							nxt_cnt_q <= nxt_cnt_q + 2'd1;
						end
					end
				end
				ST_A_ADDW: begin
					state_q <= ST_A_STEP;
				end
				ST_Q_RD: begin
					if (s_q == e_q) begin
						state_q <= ST_Q_LAST;
					end
				end
				ST_Q_LAST: begin
					state_q <= ST_Q_FIN;
				end
				ST_Q_FIN: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// Payload and walk registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q  <= (func == FUNC_ADD) ? lo_clip : low_pos;
			hi_q  <= hi_clip;
			amt_q <= amount;
			acc_q <= '0;
			s_q   <= POS_ONE;
			e_q   <= top_pos;
			k_q   <= ROOT_K;
		end
		if (qpend_q) begin
			acc_q <= acc_q + mem_rdata;
		end
		if (state_q == ST_Q_RD && s_q != e_q) begin
			if (lo_q <= q_mid) begin
				e_q <= q_mid;
				k_q <= {k_q[NODE_AW-2:0], 1'b0};
			end else begin
				s_q <= q_mid + POS_ONE;
				k_q <= {k_q[NODE_AW-2:0], 1'b1};
			end
		end
		if ((state_q == ST_A_ROOT || (state_q == ST_A_STEP && slot_live)) && cand_full) begin
			tk_q <= cand_k;
		end
		if (state_q == ST_A_ROOT && !cand_full) begin
			nxt_s_q[0] <= cand_s;
			nxt_e_q[0] <= cand_e;
			nxt_k_q[0] <= cand_k;
		end
		if (state_q == ST_A_STEP && slot_live && !cand_full && !cand_disj) begin
			nxt_s_q[nxt_cnt_q[0]] <= cand_s;
			nxt_e_q[nxt_cnt_q[0]] <= cand_e;
			nxt_k_q[nxt_cnt_q[0]] <= cand_k;
		end
		if (state_q == ST_A_STEP && !slot_live) begin
			cur_s_q <= nxt_s_q;
			cur_e_q <= nxt_e_q;
			cur_k_q <= nxt_k_q;
		end
		if (state_q == ST_Q_FIN && rsp_free) begin
			rsp_data_q <= acc_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign point_total = rsp_data_q;

	// The write of a read-modify-write goes to the node read in the previous cycle.
	a_rmw_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_A_ADDW) |-> ($past(mem_ctl.re) && mem_addr == $past(mem_addr)))
		else $error("rmw write address differs from read");

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.we && mem_ctl.re))
		else $error("node store read and write in the same cycle");

	// A contiguous span leaves at most two partial nodes per level.
	a_lvl_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_cnt_q != 2'd3) && (nxt_cnt_q != 2'd3))
		else $error("more than two partial nodes on a level");

	a_qpend: assert property (@(posedge clk) disable iff (!arst_n)
		qpend_q |-> (state_q == ST_Q_RD || state_q == ST_Q_LAST))
		else $error("query read data arrived outside the query walk");

endmodule

[rtl/range_add_point_query_tree.sv]
// Queries: point_total becomes valid after the walk has read every node on the
//   root-to-leaf path (11 nodes at 1024 positions); a point off the tree skips the walk.
//   An add is busy while it examines children level by level and updates each covering node.
// Items: one at a time on the single node RAM port; a query stalls while an earlier
//   result still waits.
// Reset: asynchronous; active_size returns to MAX_POSITIONS (capped at 2047) and a clearing
//   pass zeroes all 2^(clog2(MAX_POSITIONS)+1) node entries before req_ready rises.
module range_add_point_query_tree import rapq_pkg::*; #(
	parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// request channel
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic                      func,
	input  logic [POS_W-1:0]          low_pos,
	input  logic [POS_W-1:0]          high_pos,
	input  logic signed [VAL_W-1:0]   amount,
	// response channel
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic signed [VAL_W-1:0]   point_total,
	// configuration port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_AW-1:0]         paddr,
	input  logic [APB_DW-1:0]         pwdata,
	output logic [APB_DW-1:0]         prdata,
	output logic                      pready
);

	localparam int NODE_AW = $clog2(MAX_POSITIONS) + 1;
	// The size register is 11 bits wide, so the live range never exceeds its span.
	localparam int TOP_CAP = (MAX_POSITIONS > (1 << ACT_W) - 1) ? (1 << ACT_W) - 1 :
		MAX_POSITIONS;
	localparam logic [ACT_W-1:0] TOP_CAP_V = ACT_W'(TOP_CAP);

	logic [ACT_W-1:0]   active_size_q;
	logic [POS_W-1:0]   top_pos;
	logic               reg_hit;
	mem_ctl_t           mem_ctl;
	logic [NODE_AW-1:0] mem_addr;
	logic [VAL_W-1:0]   mem_wdata;
	logic [VAL_W-1:0]   mem_rdata;

	// Register decode: one register at byte addresses 0 to 3; writes elsewhere are dropped.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1:2] == REG_ACTIVE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_size_q <= TOP_CAP_V;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			active_size_q <= pwdata[ACT_W-1:0];
		end
	end

	assign prdata = reg_hit ? {{(APB_DW-ACT_W){1'b0}}, active_size_q} : '0;

	// Root range top: a size of zero acts as one, oversize saturates at the capacity.
	// Config must change only while idle (the block does not enforce this), so the walker sees a steady value per item.
	always_comb begin
		if (active_size_q == '0) begin
			top_pos = POS_W'(1);
		end else if (active_size_q > TOP_CAP_V) begin
			top_pos = TOP_CAP_V;
		end else begin
			top_pos = active_size_q;
		end
	end

	// Walker: decomposes adds level by level (at most two partial nodes per level)
	// and updates each covering node by read-modify-write; queries stream one read
	// per cycle down the root-to-leaf path and sum the returned addends. Each RMW
	// finishes before the next access, so no forwarding path is needed.
	rapq_walk #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.top_pos     (top_pos),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.func        (func),
		.low_pos     (low_pos),
		.high_pos    (high_pos),
		.amount      (amount),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.point_total (point_total),
		.mem_ctl     (mem_ctl),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata)
	);

	// Node addend store, heap-indexed from 1.
	rapq_node_ram #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_ram (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule
